// ===== hdl/hhaf_pkg.sv =====
// package: shared types, constants and name table of the header allowlist filter
`default_nettype none
package hhaf_pkg;

   localparam int HOLD_DEPTH_DEFAULT = 16;
   localparam int HOLD_DEPTH_MAX     = 64;
   localparam int NAME_COUNT_DEFAULT = 5;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // widths of the command word counts and of the sequencer index, sized for the largest hold buffer
   localparam int CNT_W = $clog2(HOLD_DEPTH_MAX + 1);
   localparam int IDX_W = $clog2(HOLD_DEPTH_MAX + 3);

   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_COLON = 8'h3A;

   localparam int NAME_TABLE_COUNT = 5;
   localparam int NAME_MAX_LEN     = 14;

   localparam logic [8*NAME_MAX_LEN-1:0] NAME_STR [NAME_TABLE_COUNT] = '{
      "Host", "User-Agent", "Accept", "Content-Type", "Content-Length"
   };
   localparam int NAME_LEN [NAME_TABLE_COUNT] = '{4, 10, 6, 12, 14};

   typedef enum logic [2:0] {
      PH_REQLINE,
      PH_NAME,
      PH_KEEP,
      PH_DROP,
      PH_BLANKCR,
      PH_BODY
   } phase_type;

   // one queued command: flush held bytes, then up to two direct bytes, or write one held byte
   typedef struct packed {
      logic [CNT_W-1:0] flush_cnt;
      logic [CNT_W-1:0] hold_addr;
      logic             hold_we;
      logic [1:0]       d_cnt;
      logic [7:0]       d0;
      logic [7:0]       d1;
      logic             d_valid;
      logic             last;
      logic             malformed;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic int name_len(input int i);
      int len;
      len = 0;
      if (i < NAME_TABLE_COUNT) begin
         len = NAME_LEN[i];
      end
      return len;
   endfunction

   // character p of name i, counted from the start of the name
   function automatic logic [7:0] name_char(input int i, input int p);
      logic [7:0] c;
      int len;
      c   = 8'h00;
      len = name_len(i);
      if (p < len) begin
         c = 8'(NAME_STR[i] >> (8 * (len - 1 - p)));
      end
      return c;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/hhaf_channels.sv =====
// interfaces: request byte channel and filtered result channel
`default_nettype none
interface hhaf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, in_byte, in_last, input ready);
   modport sink (input valid, in_byte, in_last, output ready);
endinterface

interface hhaf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic       run_last;
   logic       request_end;
   logic       malformed;

   modport source (output valid, out_byte, byte_valid, run_last, request_end, malformed,
                   input ready);
   modport sink (input valid, out_byte, byte_valid, run_last, request_end, malformed,
                 output ready);
endinterface
`default_nettype wire

// ===== hdl/hhaf_front.sv =====
// front end: line parser and name matcher, turns each request byte into at most one command
`default_nettype none
module hhaf_front #(
   parameter int HOLD_DEPTH = hhaf_pkg::HOLD_DEPTH_DEFAULT,
   parameter int NAME_COUNT = hhaf_pkg::NAME_COUNT_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   hhaf_req_if.sink                       req,
   input  wire hhaf_pkg::queue_status_type qstat,
   output logic                           push,
   output hhaf_pkg::cmd_type              push_cmd
);
   import hhaf_pkg::*;

   localparam int PW = $clog2(HOLD_DEPTH + 1);

   phase_type             phase_ff, phase_in;
   logic [NAME_COUNT-1:0] mask_ff, mask_in;
   logic [PW-1:0]         pos_ff, pos_in;
   logic                  cr_ff, cr_in;

   logic [NAME_COUNT-1:0] keep;
   logic                  matched;
   logic                  accept;
   logic [7:0]            b;
   logic                  eol;

   assign req.ready = !qstat.full;
   assign accept    = req.valid && req.ready;
   assign b         = req.in_byte;
   assign eol       = cr_ff && (b == CHAR_LF);

   // compare the byte against every name still in the running
   always_comb begin
      keep    = '0;
      matched = 1'b0;
      for (int i = 0; i < NAME_COUNT; i++) begin
         if (mask_ff[i] && (i < NAME_TABLE_COUNT)) begin
            if (int'(pos_ff) < name_len(i)) begin
               if (name_char(i, int'(pos_ff)) == b) begin
                  keep[i] = 1'b1;
               end
            end else if ((int'(pos_ff) == name_len(i)) && (b == CHAR_COLON)) begin
               matched = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_REQLINE;
         mask_ff  <= '1;
         pos_ff   <= '0;
         cr_ff    <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         mask_ff  <= mask_in;
         pos_ff   <= pos_in;
         cr_ff    <= cr_in;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      mask_in  = mask_ff;
      pos_in   = pos_ff;
      cr_in    = cr_ff;
      push_cmd = '0;
      push_cmd.d_valid = 1'b1;

      case (phase_ff)
         PH_REQLINE, PH_KEEP: begin
            push_cmd.d_cnt = 2'd1;
            push_cmd.d0    = b;
            if (eol) begin
               phase_in = PH_NAME;
               mask_in  = '1;
               pos_in   = '0;
               cr_in    = 1'b0;
            end else begin
               cr_in = (b == CHAR_CR);
            end
         end
         PH_DROP: begin
            if (eol) begin
               phase_in = PH_NAME;
               mask_in  = '1;
               pos_in   = '0;
               cr_in    = 1'b0;
            end else begin
               cr_in = (b == CHAR_CR);
            end
         end
         PH_BLANKCR: begin
            if (b == CHAR_LF) begin
               push_cmd.d_cnt = 2'd2;
               push_cmd.d0    = CHAR_CR;
               push_cmd.d1    = CHAR_LF;
               phase_in       = PH_BODY;
               cr_in          = 1'b0;
            end else begin
               phase_in = PH_DROP;
               cr_in    = (b == CHAR_CR);
            end
         end
         PH_NAME: begin
            if ((pos_ff == '0) && (b == CHAR_CR)) begin
               phase_in = PH_BLANKCR;
            end else if (matched) begin
               push_cmd.flush_cnt = CNT_W'(pos_ff);
               push_cmd.d_cnt     = 2'd1;
               push_cmd.d0        = b;
               phase_in           = PH_KEEP;
               cr_in              = 1'b0;
            end else if ((keep == '0) || (pos_ff >= PW'(HOLD_DEPTH))) begin
               phase_in = PH_DROP;
               cr_in    = (b == CHAR_CR);
            end else begin
               push_cmd.hold_we   = 1'b1;
               push_cmd.hold_addr = CNT_W'(pos_ff);
               push_cmd.d0        = b;
               pos_in             = pos_ff + PW'(1);
               mask_in            = keep;
            end
         end
         default: begin
            push_cmd.d_cnt = 2'd1;
            push_cmd.d0    = b;
            phase_in       = PH_BODY;
         end
      endcase

      if (req.in_last) begin
         push_cmd.last      = 1'b1;
         push_cmd.malformed = (phase_in == PH_REQLINE);
         // an unfinished name goes out raw: held bytes, then this byte
         if ((phase_in == PH_NAME) && push_cmd.hold_we) begin
            push_cmd.hold_we   = 1'b0;
            push_cmd.flush_cnt = CNT_W'(pos_ff);
            push_cmd.d_cnt     = 2'd1;
            push_cmd.d0        = b;
         end else if (phase_in == PH_BLANKCR) begin
            push_cmd.d_cnt = 2'd1;
            push_cmd.d0    = CHAR_CR;
         end
         if ((push_cmd.flush_cnt == '0) && (push_cmd.d_cnt == 2'd0)) begin
            // end-only marker
            push_cmd.d_cnt   = 2'd1;
            push_cmd.d0      = 8'h00;
            push_cmd.d_valid = 1'b0;
         end
         phase_in = PH_REQLINE;
         mask_in  = '1;
         pos_in   = '0;
         cr_in    = 1'b0;
      end
   end

   assign push = accept && ((push_cmd.d_cnt != 2'd0) || (push_cmd.flush_cnt != '0)
                            || push_cmd.hold_we);

`ifndef SYNTHESIS
   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      (accept && req.in_last) |=> (phase_ff == PH_REQLINE && pos_ff == '0 && !cr_ff))
      else $error("request end did not restart the parser");
   // the name count stays put on a kept or dropped line until the next line starts
   a_pos_only_in_name: assert property (@(posedge clock) disable iff (reset)
      (pos_ff != '0) |-> ((phase_ff != PH_REQLINE) && (phase_ff != PH_BLANKCR)
                          && (phase_ff != PH_BODY)))
      else $error("held name count outside a header line");
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= PW'(HOLD_DEPTH))
      else $error("held name count beyond hold buffer");
`endif
endmodule
`default_nettype wire

// ===== hdl/hhaf_queue.sv =====
// command queue between the parser and the output sequencer
`default_nettype none
module hhaf_queue #(
   parameter int DEPTH = hhaf_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire hhaf_pkg::cmd_type          push_cmd,
   input  wire logic                       pop,
   output hhaf_pkg::cmd_type               head_cmd,
   output hhaf_pkg::queue_status_type      qstat
);
   import hhaf_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   cmd_type       entries_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff;

   assign qstat.full  = (count_ff == CW'(DEPTH));
   assign qstat.empty = (count_ff == '0);
   assign head_cmd    = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CW'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && qstat.full && !pop))
      else $error("command queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && qstat.empty))
      else $error("command queue underflow");
`endif
endmodule
`default_nettype wire

// ===== hdl/hhaf_back.sv =====
// back end: hold buffer and output sequencer that plays out queued commands
`default_nettype none
module hhaf_back #(
   parameter int HOLD_DEPTH = hhaf_pkg::HOLD_DEPTH_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire hhaf_pkg::cmd_type          head_cmd,
   input  wire hhaf_pkg::queue_status_type qstat,
   output logic                            pop,
   hhaf_rsp_if.source                      rsp
);
   import hhaf_pkg::*;

   localparam int AW = $clog2(HOLD_DEPTH);

   logic [7:0]       held_ff [HOLD_DEPTH];
   logic [IDX_W-1:0] idx_ff;

   logic             rsp_valid_ff;
   logic [7:0]       out_byte_ff;
   logic             byte_valid_ff;
   logic             run_last_ff;
   logic             request_end_ff;
   logic             malformed_ff;

   logic             head_valid;
   logic [IDX_W-1:0] total;
   logic             has_elem;
   logic             out_free;
   logic             emit;
   logic             final_elem;
   logic             is_flush;
   logic [7:0]       elem_byte;
   logic             elem_valid;

   assign head_valid = !qstat.empty;
   assign total      = IDX_W'(head_cmd.flush_cnt) + IDX_W'(head_cmd.d_cnt);
   assign has_elem   = (total != '0);
   assign out_free   = !rsp_valid_ff || rsp.ready;
   assign emit       = head_valid && has_elem && out_free;
   assign final_elem = (idx_ff == total - IDX_W'(1));
   // a command with nothing to send only writes the hold buffer
   assign pop        = head_valid && (!has_elem || (out_free && final_elem));

   always_comb begin
      is_flush   = (idx_ff < IDX_W'(head_cmd.flush_cnt));
      elem_byte  = (idx_ff == IDX_W'(head_cmd.flush_cnt)) ? head_cmd.d0 : head_cmd.d1;
      elem_valid = is_flush ? 1'b1 : head_cmd.d_valid;
   end

   always_ff @(posedge clock) begin
      if (pop && head_cmd.hold_we) begin
         held_ff[head_cmd.hold_addr[AW-1:0]] <= head_cmd.d0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         if (out_free) begin
            rsp_valid_ff <= emit;
         end
         if (emit) begin
            idx_ff <= final_elem ? '0 : idx_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_byte_ff    <= is_flush ? held_ff[idx_ff[AW-1:0]] : elem_byte;
         byte_valid_ff  <= elem_valid;
         run_last_ff    <= final_elem;
         request_end_ff <= final_elem && head_cmd.last;
         malformed_ff   <= final_elem && head_cmd.malformed;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.out_byte    = out_byte_ff;
   assign rsp.byte_valid  = byte_valid_ff;
   assign rsp.run_last    = run_last_ff;
   assign rsp.request_end = request_end_ff;
   assign rsp.malformed   = malformed_ff;

`ifndef SYNTHESIS
   a_end_is_run_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && request_end_ff) |-> run_last_ff)
      else $error("request end not on the last result of its byte");
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      (head_valid && has_elem) |-> (idx_ff < total))
      else $error("sequencer index past end of command");
   a_idx_idle_zero: assert property (@(posedge clock) disable iff (reset)
      !head_valid |-> (idx_ff == '0))
      else $error("sequencer index left over with no command");
`endif
endmodule
`default_nettype wire

// ===== hdl/http_header_allowlist_filter.sv =====
// top level: http request header allowlist filter
//
// req_chan carries the client request one byte per request (in_byte), with
// in_last on the final byte. rsp_chan carries the filtered stream: out_byte
// with byte_valid, run_last on the last result caused by a request byte, and
// request_end plus malformed on the final result of the whole request.
// The parser takes one request per cycle while its command queue has room.
// Each request byte gives at most one command; the output sequencer sends
// one result at a time, so a byte that releases held header-name bytes
// sends each of them and then itself, and the parser runs ahead through
// the queue meanwhile. Dropped bytes send no results. A result passes
// through the queue entry, written when its request is taken, and then
// the output register before rsp_chan sees it.
// Reset clears the parser to the request line and empties the queue; the
// hold buffer needs no clearing. When rsp_chan stalls the output register
// holds its result, the sequencer waits, and req_chan.ready drops once the
// queue is full.
`default_nettype none
module http_header_allowlist_filter #(
   parameter int HOLD_DEPTH  = hhaf_pkg::HOLD_DEPTH_DEFAULT,
   parameter int NAME_COUNT  = hhaf_pkg::NAME_COUNT_DEFAULT,
   parameter int QUEUE_DEPTH = hhaf_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   hhaf_req_if.sink   req_chan,
   hhaf_rsp_if.source rsp_chan
);
   import hhaf_pkg::*;

   logic             push;
   logic             pop;
   cmd_type          push_cmd;
   cmd_type          head_cmd;
   queue_status_type qstat;

   hhaf_front #(
      .HOLD_DEPTH (HOLD_DEPTH),
      .NAME_COUNT (NAME_COUNT)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_chan),
      .qstat    (qstat),
      .push     (push),
      .push_cmd (push_cmd)
   );

   hhaf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .qstat    (qstat)
   );

   hhaf_back #(
      .HOLD_DEPTH (HOLD_DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .head_cmd (head_cmd),
      .qstat    (qstat),
      .pop      (pop),
      .rsp      (rsp_chan)
   );
endmodule
`default_nettype wire
